// ===== src/ngm_pkg.sv =====
// Package: shared widths, payload types and fixed-point constants for the node gradient block.
`default_nettype none
package ngm_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W = 32;
	localparam int SPC_W = 31;
	localparam int EPS_W = 16;
	localparam int MAG_W = 31;
	localparam int SUM_W = 35;
	localparam int SQ_W = 64;
	localparam int ROOT_W = 32;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

	typedef struct packed {
		logic signed [VAL_W-1:0] corner_000;
		logic signed [VAL_W-1:0] corner_001;
		logic signed [VAL_W-1:0] corner_010;
		logic signed [VAL_W-1:0] corner_011;
		logic signed [VAL_W-1:0] corner_100;
		logic signed [VAL_W-1:0] corner_101;
		logic signed [VAL_W-1:0] corner_110;
		logic signed [VAL_W-1:0] corner_111;
		logic [SPC_W-1:0] spacing_x;
		logic [SPC_W-1:0] spacing_y;
		logic [SPC_W-1:0] spacing_z;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] gradient_x;
		logic signed [VAL_W-1:0] gradient_y;
		logic signed [VAL_W-1:0] gradient_z;
		logic [MAG_W-1:0] gradient_magnitude;
	} out_item_t;
endpackage
`default_nettype wire

// ===== src/ngm_if.sv =====
// Interfaces: valid/ready channels for input beats, result beats and the epsilon write.
`default_nettype none
interface ngm_in_if import ngm_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ngm_out_if import ngm_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ngm_cfg_if import ngm_pkg::*; ();
	logic valid;
	logic ready;
	logic [EPS_W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/ngm_lane.sv =====
// One axis lane: magnitude of the face-difference sum, pipelined restoring divide by 4*spacing, round, saturate.
`default_nettype none
module ngm_lane import ngm_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [SUM_W-1:0] sum,
	input wire logic [SPC_W-1:0] spacing,
	output logic signed [VAL_W-1:0] grad
);
	// numerator = |S|<<F + 2*d ; quotient of that over 4*d
	localparam int NUM_W = SUM_W + FRACTION_BITS;
	localparam int DEN_W = SPC_W + 2;
	localparam int STG = NUM_W;

	logic [NUM_W-1:0] num_q [STG+1];
	logic [DEN_W-1:0] den_q [STG+1];
	logic [DEN_W:0] rem_q [STG+1];
	logic [NUM_W-1:0] quo_q [STG+1];
	logic neg_q [STG+1];

	logic [SUM_W-1:0] mag;
	logic [SPC_W-1:0] spc;

	always_comb begin
		mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		spc = (spacing == '0) ? SPC_W'(1) : spacing;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0] <= ({mag, FRACTION_BITS'(0)}) + NUM_W'({spc, 1'b0});
			den_q[0] <= {spc, 2'b00};
			rem_q[0] <= '0;
			quo_q[0] <= '0;
			neg_q[0] <= sum[SUM_W-1];
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar i = 0; i < STG; i++) begin : g_div
		logic [DEN_W+1:0] trial;
		logic [DEN_W:0] shifted;
		always_comb begin
			shifted = {rem_q[i][DEN_W-1:0], num_q[i][NUM_W-1-i]};
			trial = {1'b0, shifted} - {2'b00, den_q[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[i+1] <= num_q[i];
				den_q[i+1] <= den_q[i];
				neg_q[i+1] <= neg_q[i];
				if (!trial[DEN_W+1]) begin
					rem_q[i+1] <= trial[DEN_W:0];
					quo_q[i+1] <= quo_q[i] | (NUM_W'(1) << (NUM_W-1-i));
				end else begin
					rem_q[i+1] <= shifted;
					quo_q[i+1] <= quo_q[i];
				end
			end
		end
	end

	logic [NUM_W-1:0] q;
	always_comb begin
		q = quo_q[STG];
		if (neg_q[STG]) begin
			if (q > NUM_W'(64'h8000_0000)) grad = 32'sh8000_0000;
			else grad = VAL_W'(-q);
		end else begin
			if (q > NUM_W'(64'h7FFF_FFFF)) grad = 32'sh7FFF_FFFF;
			else grad = VAL_W'(q);
		end
	end
endmodule
`default_nettype wire

// ===== src/ngm_merge.sv =====
// Merge stage: squares of the three components, sum, pipelined integer square root, epsilon add, saturate.
`default_nettype none
module ngm_merge import ngm_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [VAL_W-1:0] gx,
	input wire logic signed [VAL_W-1:0] gy,
	input wire logic signed [VAL_W-1:0] gz,
	input wire logic [EPS_W-1:0] eps,
	output out_item_t res
);
	localparam int RS = ROOT_W;

	logic [ROOT_W-1:0] ax, ay, az;
	logic [SQ_W-1:0] sx_s1, sy_s1, sz_s1;
	logic signed [VAL_W-1:0] gx_s1, gy_s1, gz_s1;

	// digit-by-digit root, one result bit per stage; entry 0 holds the summed squares
	logic [SQ_W-1:0] v_q [RS+1];
	logic [ROOT_W+1:0] r_q [RS+1];
	logic [ROOT_W-1:0] rt_q [RS+1];
	logic signed [VAL_W-1:0] px_q [RS+1], py_q [RS+1], pz_q [RS+1];

	always_comb begin
		ax = gx[VAL_W-1] ? ROOT_W'(-gx) : ROOT_W'(gx);
		ay = gy[VAL_W-1] ? ROOT_W'(-gy) : ROOT_W'(gy);
		az = gz[VAL_W-1] ? ROOT_W'(-gz) : ROOT_W'(gz);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= ax * ax;
			sy_s1 <= ay * ay;
			sz_s1 <= az * az;
			gx_s1 <= gx; gy_s1 <= gy; gz_s1 <= gz;
			v_q[0] <= sx_s1 + sy_s1 + sz_s1;
			r_q[0] <= '0;
			rt_q[0] <= '0;
			px_q[0] <= gx_s1; py_q[0] <= gy_s1; pz_q[0] <= gz_s1;
		end
	end

	for (genvar i = 0; i < RS; i++) begin : g_rt
		logic [ROOT_W+1:0] cur;
		logic [ROOT_W+2:0] trial;
		always_comb begin
			cur = {r_q[i][ROOT_W-1:0], v_q[i][SQ_W-1-2*i -: 2]};
			trial = {1'b0, cur} - {1'b0, rt_q[i], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				v_q[i+1] <= v_q[i];
				px_q[i+1] <= px_q[i]; py_q[i+1] <= py_q[i]; pz_q[i+1] <= pz_q[i];
				if (!trial[ROOT_W+2]) begin
					r_q[i+1] <= trial[ROOT_W+1:0];
					rt_q[i+1] <= {rt_q[i][ROOT_W-2:0], 1'b1};
				end else begin
					r_q[i+1] <= cur;
					rt_q[i+1] <= {rt_q[i][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	logic [ROOT_W:0] m;
	always_comb begin
		m = {1'b0, rt_q[RS]} + (ROOT_W+1)'(eps);
		res.gradient_x = px_q[RS];
		res.gradient_y = py_q[RS];
		res.gradient_z = pz_q[RS];
		res.gradient_magnitude = (m > (ROOT_W+1)'(33'h7FFF_FFFF)) ? MAG_W'(31'h7FFF_FFFF)
			: MAG_W'(m);
	end
endmodule
`default_nettype wire

// ===== src/node_gradient_with_magnitude.sv =====
// Top level: three axis lanes and a merge stage in one stall-together pipeline.
//  channel | dir | payload
//  in      | in  | eight corners, three spacings
//  out     | out | three gradients, magnitude
//  cfg     | in  | magnitude_epsilon
// One beat per cycle while the output is not stalled. A beat passes through the divider
// input register and 35+F divider stages, square and sum stages, 32 root stages and the
// output register. The whole pipeline advances when the output register is empty or
// taken; a stalled output freezes every stage. Reset clears valid bits and sets epsilon
// to 1.
`default_nettype none
module node_gradient_with_magnitude import ngm_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ngm_in_if.sink in,
	ngm_out_if.source out,
	ngm_cfg_if.sink cfg
);
	localparam int LAT = 1 + SUM_W + FRACTION_BITS + 2 + ROOT_W;

	logic [EPS_W-1:0] eps_q;
	logic [LAT-1:0] vld_q;
	logic en;
	out_item_t res;
	out_item_t out_q;
	logic out_vld_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eps_q <= EPS_RESET;
		else if (cfg.valid) eps_q <= cfg.data;
	end

	assign en = !out_vld_q || out.ready;
	assign in.ready = en;

	logic signed [SUM_W-1:0] sx, sy, sz;
	always_comb begin
		sx = SUM_W'(in.data.corner_100) + SUM_W'(in.data.corner_101)
			+ SUM_W'(in.data.corner_110) + SUM_W'(in.data.corner_111)
			- SUM_W'(in.data.corner_000) - SUM_W'(in.data.corner_001)
			- SUM_W'(in.data.corner_010) - SUM_W'(in.data.corner_011);
		sy = SUM_W'(in.data.corner_010) + SUM_W'(in.data.corner_011)
			+ SUM_W'(in.data.corner_110) + SUM_W'(in.data.corner_111)
			- SUM_W'(in.data.corner_000) - SUM_W'(in.data.corner_001)
			- SUM_W'(in.data.corner_100) - SUM_W'(in.data.corner_101);
		sz = SUM_W'(in.data.corner_001) + SUM_W'(in.data.corner_011)
			+ SUM_W'(in.data.corner_101) + SUM_W'(in.data.corner_111)
			- SUM_W'(in.data.corner_000) - SUM_W'(in.data.corner_010)
			- SUM_W'(in.data.corner_100) - SUM_W'(in.data.corner_110);
	end

	logic signed [VAL_W-1:0] gx, gy, gz;
	ngm_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lx (.clk, .en, .sum(sx),
		.spacing(in.data.spacing_x), .grad(gx));
	ngm_lane #(.FRACTION_BITS(FRACTION_BITS)) u_ly (.clk, .en, .sum(sy),
		.spacing(in.data.spacing_y), .grad(gy));
	ngm_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lz (.clk, .en, .sum(sz),
		.spacing(in.data.spacing_z), .grad(gz));

	ngm_merge u_merge (.clk, .en, .gx, .gy, .gz, .eps(eps_q), .res);

	// valid shift line; last stage feeds the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in.valid};
			out_vld_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= res;
	end

	assign out.valid = out_vld_q;
	assign out.data = out_q;
endmodule
`default_nettype wire

// ===== src/ngm_checker.sv =====
// Checker: port-level properties of the node gradient block, bound to the top level.
`default_nettype none
module ngm_checker import ngm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");
endmodule

bind node_gradient_with_magnitude ngm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready), .out_valid(out.valid),
	.out_ready(out.ready), .out_data(out.data));
`default_nettype wire

// ===== tb/ngm_checker.sv =====
// Checker: predicts gradient beats from accepted input beats and compares result beats.
`default_nettype none
module ngm_tb_checker import ngm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ngm_in_if in_mon,
	ngm_out_if out_mon,
	ngm_cfg_if cfg_mon,
	output int errors,
	output int pending
);
	out_item_t grad_queue[$];
	logic [EPS_W-1:0] epsilon;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	// rounded |S|*2^16/(4d), sign applied, saturated
	function automatic logic signed [63:0] axis_grad(input logic signed [63:0] s,
			input logic [SPC_W-1:0] spc);
		logic [63:0] m, den, q;
		logic neg;
		neg = s < 0;
		m = neg ? -s : s;
		den = (spc == 0 ? 64'd1 : 64'(spc)) * 4;
		q = ((m << 16) + den / 2) / den;
		if (neg) return (q > 64'h8000_0000) ? -64'sh8000_0000 : -$signed(q);
		return (q > 64'h7fff_ffff) ? 64'sh7fff_ffff : $signed(q);
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic out_item_t predict_gradient(input in_item_t x);
		logic signed [63:0] c[8], sx, sy, sz, gx, gy, gz;
		logic [63:0] ax, ay, az, m;
		out_item_t r;
		c[0] = x.corner_000; c[1] = x.corner_001; c[2] = x.corner_010; c[3] = x.corner_011;
		c[4] = x.corner_100; c[5] = x.corner_101; c[6] = x.corner_110; c[7] = x.corner_111;
		sx = 0; sy = 0; sz = 0;
		for (int i = 0; i < 8; i++) begin
			sx += (i & 4) ? c[i] : -c[i];
			sy += (i & 2) ? c[i] : -c[i];
			sz += (i & 1) ? c[i] : -c[i];
		end
		gx = axis_grad(sx, x.spacing_x);
		gy = axis_grad(sy, x.spacing_y);
		gz = axis_grad(sz, x.spacing_z);
		ax = gx < 0 ? -gx : gx;
		ay = gy < 0 ? -gy : gy;
		az = gz < 0 ? -gz : gz;
		m = root_floor(ax * ax + ay * ay + az * az) + epsilon;
		if (m > 64'h7fff_ffff) m = 64'h7fff_ffff;
		r.gradient_x = gx[31:0];
		r.gradient_y = gy[31:0];
		r.gradient_z = gz[31:0];
		r.gradient_magnitude = m[30:0];
		return r;
	endfunction

	assign pending = grad_queue.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			epsilon <= EPS_RESET;
			errors = 0;
			grad_queue.delete();
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) epsilon <= cfg_mon.data;
			if (in_mon.valid && in_mon.ready) grad_queue.push_back(predict_gradient(in_mon.data));
			if (out_mon.valid && out_mon.ready) begin
				if (grad_queue.size() == 0) begin
					report("unexpected beat", out_mon.data.gradient_x, 0);
				end else begin
					e = grad_queue.pop_front();
					if (out_mon.data.gradient_x !== e.gradient_x)
						report("gradient_x", out_mon.data.gradient_x, e.gradient_x);
					if (out_mon.data.gradient_y !== e.gradient_y)
						report("gradient_y", out_mon.data.gradient_y, e.gradient_y);
					if (out_mon.data.gradient_z !== e.gradient_z)
						report("gradient_z", out_mon.data.gradient_z, e.gradient_z);
					if (out_mon.data.gradient_magnitude !== e.gradient_magnitude)
						report("gradient_magnitude", out_mon.data.gradient_magnitude,
							e.gradient_magnitude);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/node_gradient_with_magnitude_tb.sv =====
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict.
`default_nettype none
module node_gradient_with_magnitude_tb;
	import ngm_pkg::*;

	localparam int LATENCY = (35 + 16) + 2 + 32 + 1;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	int errors, pending, cycles = 0;
	logic stall_mode = 0;

	ngm_in_if in_ch();
	ngm_out_if out_ch();
	ngm_cfg_if cfg_ch();

	node_gradient_with_magnitude dut(.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch),
		.cfg(cfg_ch));
	ngm_tb_checker chk(.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.cfg_mon(cfg_ch), .errors(errors), .pending(pending));

	always #6 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("node_gradient_with_magnitude_tb NOT OK");
			$finish;
		end
	end

	// receiver: stall pattern switches between a mostly-ready mode and a sparse accept
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
		if (stall_mode) out_ch.ready <= ($urandom_range(0, 3) == 0);
		else out_ch.ready <= ($urandom_range(0, 9) != 0);
	end

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SPC_W-1:0] rand_spacing();
		case ($urandom_range(0, 5))
			0: return 31'd1;
			1: return 31'h7fff_ffff;
			2: return SPC_W'($urandom_range(1, 300));
			3: return 31'h0001_0000;
			default: return SPC_W'($urandom);
		endcase
	endfunction

	task automatic send_beat(input in_item_t x);
		in_ch.valid <= 1;
		in_ch.data <= x;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic go_idle();
		in_ch.valid <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [EPS_W-1:0] v);
		cfg_ch.valid <= 1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic fill(output in_item_t x, input logic [31:0] v, input logic [SPC_W-1:0] s);
		x.corner_000 = v; x.corner_001 = v; x.corner_010 = v; x.corner_011 = v;
		x.corner_100 = v; x.corner_101 = v; x.corner_110 = v; x.corner_111 = v;
		x.spacing_x = s; x.spacing_y = s; x.spacing_z = s;
	endtask

	task automatic random_phase(input int n);
		in_item_t x;
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && n > 0; i++, n--) begin
				x.corner_000 = rand_val(); x.corner_001 = rand_val();
				x.corner_010 = rand_val(); x.corner_011 = rand_val();
				x.corner_100 = rand_val(); x.corner_101 = rand_val();
				x.corner_110 = rand_val(); x.corner_111 = rand_val();
				x.spacing_x = rand_spacing(); x.spacing_y = rand_spacing();
				x.spacing_z = rand_spacing();
				send_beat(x);
			end
			if ($urandom_range(0, 2) != 0) begin
				go_idle();
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		go_idle();
	endtask

	initial begin
		in_item_t x;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: flat field, extreme swings, min/max spacing
		fill(x, 32'h0, 31'h1_0000); send_beat(x);
		fill(x, 32'h7fff_ffff, 31'd1); send_beat(x);
		fill(x, 32'h8000_0000, 31'h7fff_ffff); send_beat(x);
		for (int k = 0; k < 3; k++) begin
			fill(x, 32'h8000_0000, 31'd1);
			if (k == 0) begin
				x.corner_100 = 32'h7fff_ffff; x.corner_101 = 32'h7fff_ffff;
				x.corner_110 = 32'h7fff_ffff; x.corner_111 = 32'h7fff_ffff;
			end else if (k == 1) begin
				x.corner_010 = 32'h7fff_ffff; x.corner_011 = 32'h7fff_ffff;
				x.corner_110 = 32'h7fff_ffff; x.corner_111 = 32'h7fff_ffff;
			end else begin
				x.corner_001 = 32'h7fff_ffff; x.corner_011 = 32'h7fff_ffff;
				x.corner_101 = 32'h7fff_ffff; x.corner_111 = 32'h7fff_ffff;
			end
			send_beat(x);
		end
		// all three axes saturated together, magnitude saturates; then again with zero spacing
		fill(x, 32'h8000_0000, 31'd1);
		x.corner_111 = 32'h7fff_ffff; send_beat(x);
		x.spacing_x = 0; x.spacing_y = 0; x.spacing_z = 0; send_beat(x);
		// rounding: sum 2, spacing 2^17 gives exactly a quarter of an LSB
		fill(x, 32'h0, 31'h2_0000);
		x.corner_100 = 32'd1; x.corner_101 = 32'd1; send_beat(x);
		x.corner_100 = -32'sd1; x.corner_101 = -32'sd1; send_beat(x);
		x.corner_000 = 32'hffff_ffff; x.corner_111 = 32'h5555_5555; send_beat(x);
		go_idle();
		drain();

		write_epsilon(16'hffff);
		random_phase(300);
		drain();
		write_epsilon(16'h0);
		random_phase(300);
		drain();
		write_epsilon(16'($urandom));
		random_phase(250);
		drain();
		write_epsilon(16'd1);
		random_phase(290);
		drain();

		if (errors == 0)
			$display("node_gradient_with_magnitude_tb OK");
		else
			$display("node_gradient_with_magnitude_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
